### rtl/core/clle_pkg.sv
// Shared types, codes and constants of the cursor linked list engine.
package clle_pkg;

  // Field widths of one request beat and one result beat
  localparam int unsigned OpW   = 3;
  localparam int unsigned ValW  = 32;
  localparam int unsigned PosW  = 8;
  localparam int unsigned StatW = 2;

  // Default size of the node store
  localparam int unsigned NodeCountDefault = 256;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_MAKE_EMPTY  = 3'd0,
    OP_INSERT      = 3'd1,
    OP_DELETE      = 3'd2,
    OP_FIND        = 3'd3,
    OP_DELETE_LIST = 3'd4,
    OP_READ        = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_SPACE     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_BAD_POS   = 2'd3
  } status_e;

  // Datapath micro-operations, one per cycle
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_RES_BAD,
    CMD_RES_SPACE,
    CMD_RES_NOT_FOUND,
    CMD_RES_ZERO,
    CMD_RD_ISSUE,
    CMD_RD_DONE,
    CMD_TAKE_ISSUE,
    CMD_TAKE_DONE,
    CMD_FREE_ISSUE,
    CMD_FREE_FIRST,
    CMD_FREE_STEP,
    CMD_ME_DONE,
    CMD_INS_ISSUE,
    CMD_INS_POP,
    CMD_INS_LINK,
    CMD_INS_DONE,
    CMD_SEEK_ISSUE,
    CMD_SEEK_FIRST,
    CMD_SEEK_STEP,
    CMD_FIND_DONE,
    CMD_DEL_UNLINK,
    CMD_DEL_DONE
  } dp_cmd_e;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           head_zero;
    logic           head_high;
    logic           pos_bad;
    logic           free_empty;
    logic           link_zero;
    logic           elem_match;
    logic           steps_last;
  } dp_stat_t;

  // One request beat
  typedef struct packed {
    logic [OpW-1:0]         operation;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]        list_head;
    logic [PosW-1:0]        position;
  } in_item_t;

  // One result beat
  typedef struct packed {
    status_e                status;
    logic [PosW-1:0]        found_position;
    logic [PosW-1:0]        previous_position;
    logic signed [ValW-1:0] element;
    logic [PosW-1:0]        next_position;
  } res_t;

endpackage

### rtl/core/clle_if.sv
// Request and result channel interfaces of the cursor linked list engine.
interface clle_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [clle_pkg::OpW-1:0]             operation;
  logic signed [clle_pkg::ValW-1:0]     value;
  logic [clle_pkg::PosW-1:0]            list_head;
  logic [clle_pkg::PosW-1:0]            position;

  modport source (output valid, operation, value, list_head, position, input ready);
  modport sink (input valid, operation, value, list_head, position, output ready);
endinterface

interface clle_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [clle_pkg::StatW-1:0]           status;
  logic [clle_pkg::PosW-1:0]            found_position;
  logic [clle_pkg::PosW-1:0]            previous_position;
  logic signed [clle_pkg::ValW-1:0]     element;
  logic [clle_pkg::PosW-1:0]            next_position;

  modport source (output valid, status, found_position, previous_position, element,
                  next_position, input ready);
  modport sink (input valid, status, found_position, previous_position, element,
                next_position, output ready);
endinterface

### rtl/core/clle_ram.sv
// Generic single-write, single-read RAM with registered, write-through read.
module clle_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);
  localparam int unsigned AddrW = $clog2(Depth);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;
  logic [AddrW-1:0] waddr;

  assign waddr = waddr_i;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr] <= wdata_i;
    end
  end

  // Read port: a same-cycle write to the read address is passed through
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/clle_dp.sv
// Datapath: node stores, free list head, walk pointers and the result register.
module clle_dp #(
  parameter int unsigned NodeCount = clle_pkg::NodeCountDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clle_pkg::dp_cmd_e  cmd_i,
  input  clle_pkg::in_item_t item_i,
  output clle_pkg::dp_stat_t stat_o,
  output clle_pkg::res_t     res_o
);
  import clle_pkg::*;

  localparam int unsigned AddrW = $clog2(NodeCount);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(NodeCount - 1);

  // Latched request
  logic [OpW-1:0]         op_q, op_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic [PosW-1:0]        head_q, head_d;
  logic [PosW-1:0]        pos_q, pos_d;

  // Walk and allocation state
  logic [AddrW-1:0] p_q, p_d;
  logic [AddrW-1:0] n_q, n_d;
  logic [AddrW-1:0] found_q, found_d;
  logic [AddrW-1:0] free_q, free_d;
  logic [AddrW-1:0] steps_q, steps_d;
  res_t             res_q, res_d;

  // Store ports
  logic             lk_re, lk_we;
  logic [AddrW-1:0] lk_raddr, lk_waddr, lk_wdata, lk_rdata;
  logic             el_re, el_we;
  logic [AddrW-1:0] el_raddr, el_waddr;
  logic [ValW-1:0]  el_wdata, el_rdata;

  logic [AddrW-1:0] head_a, pos_a;
  logic             steps_last;

  assign head_a     = AddrW'(head_q);
  assign pos_a      = AddrW'(pos_q);
  assign steps_last = (steps_q == LastAddr);

  // Status toward the controller
  assign stat_o.op         = op_q;
  assign stat_o.head_zero  = (head_q == '0);
  assign stat_o.head_high  = (32'(head_q) >= NodeCount);
  assign stat_o.pos_bad    = (pos_q == '0) || (32'(pos_q) >= NodeCount);
  assign stat_o.free_empty = (free_q == '0);
  assign stat_o.link_zero  = (lk_rdata == '0);
  assign stat_o.elem_match = (el_rdata == val_q);
  assign stat_o.steps_last = steps_last;

  assign res_o = res_q;

  // Micro-operation decode
  always_comb begin
    op_d     = op_q;
    val_d    = val_q;
    head_d   = head_q;
    pos_d    = pos_q;
    p_d      = p_q;
    n_d      = n_q;
    found_d  = found_q;
    free_d   = free_q;
    steps_d  = steps_q;
    res_d    = res_q;
    lk_re    = 1'b0;
    lk_raddr = '0;
    lk_we    = 1'b0;
    lk_waddr = '0;
    lk_wdata = '0;
    el_re    = 1'b0;
    el_raddr = '0;
    el_we    = 1'b0;
    el_waddr = '0;
    el_wdata = '0;
    unique case (cmd_i)
      CMD_NONE: begin
      end
      // Reset sweep: chain every node, zero every element
      CMD_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = steps_q;
        lk_wdata = steps_last ? '0 : steps_q + 1'b1;
        el_we    = 1'b1;
        el_waddr = steps_q;
        steps_d  = steps_last ? '0 : steps_q + 1'b1;
      end
      CMD_LOAD: begin
        op_d   = item_i.operation;
        val_d  = item_i.value;
        head_d = item_i.list_head;
        pos_d  = item_i.position;
      end
      CMD_RES_BAD: begin
        res_d        = '0;
        res_d.status = STAT_BAD_POS;
      end
      CMD_RES_SPACE: begin
        res_d        = '0;
        res_d.status = STAT_SPACE;
      end
      CMD_RES_NOT_FOUND: begin
        res_d        = '0;
        res_d.status = STAT_NOT_FOUND;
      end
      CMD_RES_ZERO: begin
        res_d        = '0;
        res_d.status = STAT_OK;
      end
      // Node read
      CMD_RD_ISSUE: begin
        lk_re    = 1'b1;
        lk_raddr = pos_a;
        el_re    = 1'b1;
        el_raddr = pos_a;
      end
      CMD_RD_DONE: begin
        res_d               = '0;
        res_d.status        = STAT_OK;
        res_d.element       = el_rdata;
        res_d.next_position = PosW'(lk_rdata);
      end
      // Header allocation from the free list
      CMD_TAKE_ISSUE: begin
        found_d  = free_q;
        lk_re    = 1'b1;
        lk_raddr = free_q;
      end
      CMD_TAKE_DONE: begin
        free_d               = lk_rdata;
        lk_we                = 1'b1;
        lk_waddr             = found_q;
        res_d                = '0;
        res_d.status         = STAT_OK;
        res_d.found_position = PosW'(found_q);
      end
      // Freeing every node after a header
      CMD_FREE_ISSUE: begin
        lk_re    = 1'b1;
        lk_raddr = head_a;
      end
      CMD_FREE_FIRST: begin
        lk_we    = 1'b1;
        lk_waddr = head_a;
        p_d      = lk_rdata;
        lk_re    = 1'b1;
        lk_raddr = lk_rdata;
        steps_d  = '0;
      end
      CMD_FREE_STEP: begin
        lk_we    = 1'b1;
        lk_waddr = p_q;
        lk_wdata = free_q;
        free_d   = p_q;
        p_d      = lk_rdata;
        lk_re    = 1'b1;
        lk_raddr = lk_rdata;
        steps_d  = steps_q + 1'b1;
      end
      // Old header goes back and comes straight out again as the new one;
      // its link is cleared again since the walk may have reached it
      CMD_ME_DONE: begin
        lk_we                = 1'b1;
        lk_waddr             = head_a;
        lk_wdata             = '0;
        res_d                = '0;
        res_d.status         = STAT_OK;
        res_d.found_position = head_q;
      end
      // Insert after a node
      CMD_INS_ISSUE: begin
        found_d  = free_q;
        lk_re    = 1'b1;
        lk_raddr = free_q;
        el_we    = 1'b1;
        el_waddr = free_q;
        el_wdata = val_q;
      end
      CMD_INS_POP: begin
        free_d   = lk_rdata;
        lk_re    = 1'b1;
        lk_raddr = pos_a;
      end
      CMD_INS_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = found_q;
        lk_wdata = lk_rdata;
      end
      CMD_INS_DONE: begin
        lk_we                   = 1'b1;
        lk_waddr                = pos_a;
        lk_wdata                = found_q;
        res_d                   = '0;
        res_d.status            = STAT_OK;
        res_d.found_position    = PosW'(found_q);
        res_d.previous_position = pos_q;
      end
      // Search: one node per cycle, link and element fetched together
      CMD_SEEK_ISSUE: begin
        p_d      = head_a;
        lk_re    = 1'b1;
        lk_raddr = head_a;
      end
      CMD_SEEK_FIRST: begin
        n_d      = lk_rdata;
        lk_re    = 1'b1;
        lk_raddr = lk_rdata;
        el_re    = 1'b1;
        el_raddr = lk_rdata;
        steps_d  = '0;
      end
      CMD_SEEK_STEP: begin
        p_d      = n_q;
        n_d      = lk_rdata;
        lk_re    = 1'b1;
        lk_raddr = lk_rdata;
        el_re    = 1'b1;
        el_raddr = lk_rdata;
        steps_d  = steps_q + 1'b1;
      end
      CMD_FIND_DONE: begin
        res_d                   = '0;
        res_d.status            = STAT_OK;
        res_d.found_position    = PosW'(n_q);
        res_d.previous_position = PosW'(p_q);
      end
      // Delete: bypass the node, then push it on the free list
      CMD_DEL_UNLINK: begin
        lk_we    = 1'b1;
        lk_waddr = p_q;
        lk_wdata = lk_rdata;
      end
      CMD_DEL_DONE: begin
        lk_we                   = 1'b1;
        lk_waddr                = n_q;
        lk_wdata                = free_q;
        free_d                  = n_q;
        res_d                   = '0;
        res_d.status            = STAT_OK;
        res_d.found_position    = PosW'(n_q);
        res_d.previous_position = PosW'(p_q);
      end
      default: begin
      end
    endcase
  end

  // Free list head and walk counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= AddrW'(1);
      steps_q <= '0;
    end else begin
      free_q  <= free_d;
      steps_q <= steps_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    val_q   <= val_d;
    head_q  <= head_d;
    pos_q   <= pos_d;
    p_q     <= p_d;
    n_q     <= n_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  // Link store
  clle_ram #(
    .DataW (AddrW),
    .Depth (NodeCount)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .re_i    (lk_re),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  // Element store
  clle_ram #(
    .DataW (ValW),
    .Depth (NodeCount)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (el_we),
    .waddr_i (el_waddr),
    .wdata_i (el_wdata),
    .re_i    (el_re),
    .raddr_i (el_raddr),
    .rdata_o (el_rdata)
  );

  // A node is only taken when the free list was not empty
  a_take_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_TAKE_DONE) |-> (found_q != '0))
    else $error("header taken from an empty free list");

  a_ins_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_INS_ISSUE) |-> (free_q != '0))
    else $error("insert started with an empty free list");

  // A deleted node is never the null position
  a_del_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_DEL_DONE) |-> (n_q != '0))
    else $error("null node pushed onto the free list");

endmodule

### rtl/core/clle_ctrl.sv
// Controller: sequences each operation as datapath micro-operations.
module clle_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output clle_pkg::dp_cmd_e  cmd_o,
  input  clle_pkg::dp_stat_t stat_i
);
  import clle_pkg::*;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_DISP = 4'd2;
  localparam logic [3:0] ST_FR1  = 4'd3;
  localparam logic [3:0] ST_FR2  = 4'd4;
  localparam logic [3:0] ST_FRD  = 4'd5;
  localparam logic [3:0] ST_TK   = 4'd6;
  localparam logic [3:0] ST_IN1  = 4'd7;
  localparam logic [3:0] ST_IN2  = 4'd8;
  localparam logic [3:0] ST_IN3  = 4'd9;
  localparam logic [3:0] ST_SK1  = 4'd10;
  localparam logic [3:0] ST_SK2  = 4'd11;
  localparam logic [3:0] ST_DL   = 4'd12;
  localparam logic [3:0] ST_RD1  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       gives_result;
  dp_cmd_e    cmd;

  // Result register can take a new beat this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  // Micro-operations that load the result register
  always_comb begin
    unique case (cmd)
      CMD_RES_BAD, CMD_RES_SPACE, CMD_RES_NOT_FOUND, CMD_RES_ZERO, CMD_RD_DONE,
      CMD_TAKE_DONE, CMD_ME_DONE, CMD_INS_DONE, CMD_FIND_DONE, CMD_DEL_DONE:
        gives_result = 1'b1;
      default: gives_result = 1'b0;
    endcase
  end

  // Next state and command
  always_comb begin
    state_d = state_q;
    cmd     = CMD_NONE;
    unique case (state_q)
      ST_CLR: begin
        cmd = CMD_CLEAR;
        if (stat_i.steps_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd     = CMD_LOAD;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (stat_i.op)
          OP_MAKE_EMPTY: begin
            if (stat_i.head_high) begin
              if (slot_free) begin
                cmd     = CMD_RES_BAD;
                state_d = ST_IDLE;
              end
            end else if (!stat_i.head_zero) begin
              cmd     = CMD_FREE_ISSUE;
              state_d = ST_FR1;
            end else if (stat_i.free_empty) begin
              if (slot_free) begin
                cmd     = CMD_RES_SPACE;
                state_d = ST_IDLE;
              end
            end else begin
              cmd     = CMD_TAKE_ISSUE;
              state_d = ST_TK;
            end
          end
          OP_INSERT: begin
            if (stat_i.pos_bad) begin
              if (slot_free) begin
                cmd     = CMD_RES_BAD;
                state_d = ST_IDLE;
              end
            end else if (stat_i.free_empty) begin
              if (slot_free) begin
                cmd     = CMD_RES_SPACE;
                state_d = ST_IDLE;
              end
            end else begin
              cmd     = CMD_INS_ISSUE;
              state_d = ST_IN1;
            end
          end
          OP_DELETE, OP_FIND: begin
            if (stat_i.head_zero || stat_i.head_high) begin
              if (slot_free) begin
                cmd     = CMD_RES_BAD;
                state_d = ST_IDLE;
              end
            end else begin
              cmd     = CMD_SEEK_ISSUE;
              state_d = ST_SK1;
            end
          end
          OP_DELETE_LIST: begin
            if (stat_i.head_zero || stat_i.head_high) begin
              if (slot_free) begin
                cmd     = CMD_RES_BAD;
                state_d = ST_IDLE;
              end
            end else begin
              cmd     = CMD_FREE_ISSUE;
              state_d = ST_FR1;
            end
          end
          OP_READ: begin
            if (stat_i.pos_bad) begin
              if (slot_free) begin
                cmd     = CMD_RES_BAD;
                state_d = ST_IDLE;
              end
            end else begin
              cmd     = CMD_RD_ISSUE;
              state_d = ST_RD1;
            end
          end
          default: begin
            // Unused operation codes: no change, empty ok result
            if (slot_free) begin
              cmd     = CMD_RES_ZERO;
              state_d = ST_IDLE;
            end
          end
        endcase
      end
      // Free walk
      ST_FR1: begin
        cmd     = CMD_FREE_FIRST;
        state_d = stat_i.link_zero ? ST_FRD : ST_FR2;
      end
      ST_FR2: begin
        cmd = CMD_FREE_STEP;
        if (stat_i.link_zero || stat_i.steps_last) begin
          state_d = ST_FRD;
        end
      end
      ST_FRD: begin
        if (slot_free) begin
          if (stat_i.op == OP_MAKE_EMPTY) begin
            cmd = CMD_ME_DONE;
          end else begin
            cmd = CMD_RES_ZERO;
          end
          state_d = ST_IDLE;
        end
      end
      ST_TK: begin
        if (slot_free) begin
          cmd     = CMD_TAKE_DONE;
          state_d = ST_IDLE;
        end
      end
      // Insert
      ST_IN1: begin
        cmd     = CMD_INS_POP;
        state_d = ST_IN2;
      end
      ST_IN2: begin
        cmd     = CMD_INS_LINK;
        state_d = ST_IN3;
      end
      ST_IN3: begin
        if (slot_free) begin
          cmd     = CMD_INS_DONE;
          state_d = ST_IDLE;
        end
      end
      // Search walk
      ST_SK1: begin
        if (stat_i.link_zero) begin
          if (slot_free) begin
            cmd     = CMD_RES_NOT_FOUND;
            state_d = ST_IDLE;
          end
        end else begin
          cmd     = CMD_SEEK_FIRST;
          state_d = ST_SK2;
        end
      end
      ST_SK2: begin
        if (stat_i.elem_match) begin
          if (stat_i.op == OP_FIND) begin
            if (slot_free) begin
              cmd     = CMD_FIND_DONE;
              state_d = ST_IDLE;
            end
          end else begin
            cmd     = CMD_DEL_UNLINK;
            state_d = ST_DL;
          end
        end else if (stat_i.link_zero || stat_i.steps_last) begin
          if (slot_free) begin
            cmd     = CMD_RES_NOT_FOUND;
            state_d = ST_IDLE;
          end
        end else begin
          cmd = CMD_SEEK_STEP;
        end
      end
      ST_DL: begin
        if (slot_free) begin
          cmd     = CMD_DEL_DONE;
          state_d = ST_IDLE;
        end
      end
      ST_RD1: begin
        if (slot_free) begin
          cmd     = CMD_RD_DONE;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = gives_result || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // Result register is never overwritten while a beat is still pending
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gives_result |-> slot_free)
    else $error("result loaded over a pending beat");

  // No request is taken during the reset sweep
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !in_ready_o)
    else $error("request accepted during store sweep");

  // Every finished operation leaves a result behind
  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_CLR && state_d == ST_IDLE) |=> out_valid_q)
    else $error("operation ended without a result");

endmodule

### rtl/core/cursor_linked_list_engine.sv
// Top level of the cursor linked list engine: controller, datapath and channels.
//
//  channel | dir | handshake     | beat
//  --------+-----+---------------+-----------------------------------------------
//  in_i    | in  | valid / ready | operation, value, list_head, position
//  out_o   | out | valid / ready | status, found_position, previous_position,
//          |     |               | element, next_position
//
// One operation at a time. Rejected requests are answered from the dispatch step, reads
// and make_empty without a list after one store access; insert pops a free node, links it
// and then links the position to it; find walks the list node by node, delete adds an
// unlink step, delete_list and make_empty with a list walk the nodes freed; the walks
// are set by one link-store read per node. After reset the stores are swept with
// in_i.ready low. A held result beat stalls only the final step of the next
// operation; the next request is still taken while it waits.
module cursor_linked_list_engine #(
  parameter int unsigned NodeCount = clle_pkg::NodeCountDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  clle_in_if.sink    in_i,
  clle_out_if.source out_o
);
  import clle_pkg::*;

  dp_cmd_e  cmd;
  dp_stat_t stat;
  in_item_t item;
  res_t     res;

  // Request beat into the datapath
  assign item.operation = in_i.operation;
  assign item.value     = in_i.value;
  assign item.list_head = in_i.list_head;
  assign item.position  = in_i.position;

  // Result beat out of the datapath
  assign out_o.status            = res.status;
  assign out_o.found_position    = res.found_position;
  assign out_o.previous_position = res.previous_position;
  assign out_o.element           = res.element;
  assign out_o.next_position     = res.next_position;

  clle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  clle_dp #(
    .NodeCount (NodeCount)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .item_i (item),
    .stat_o (stat),
    .res_o  (res)
  );

endmodule

### tb/sv/clle_checker.sv
// Scoreboard of the cursor linked list engine: predicts every result beat and checks it.
module clle_checker (
  input  logic clk_i,
  input  logic rst_ni,
  clle_in_if   req_i,
  clle_out_if  res_i,
  output int   fail_count_o,
  output int   open_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import clle_pkg::*;

  localparam int unsigned Nodes = NodeCountDefault;

  // Shadow node store: next link and element of every node, node 0 heads the free list
  int unsigned     link_mem [Nodes];
  logic [ValW-1:0] elem_mem [Nodes];
  res_t            results_due [$];
  int              mismatches = 0;
  int              pending = 0;

  assign fail_count_o = mismatches;
  assign open_count_o = pending;

  function automatic int unsigned pop_free();
    int unsigned n;
    n = link_mem[0];
    if (n != 0) link_mem[0] = link_mem[n];
    return n;
  endfunction

  function automatic void push_free(int unsigned n);
    link_mem[n] = link_mem[0];
    link_mem[0] = n;
  endfunction

  // Detach everything after a header and hand it back; bounded by one pass over the store
  function automatic void release_chain(int unsigned head);
    int unsigned p, t;
    p = link_mem[head];
    link_mem[head] = 0;
    for (int s = 0; s < Nodes && p != 0; s++) begin
      t = link_mem[p];
      push_free(p);
      p = t;
    end
  endfunction

  // Applies one request to the shadow store and returns the beat it should produce
  function automatic res_t predict_result(in_item_t rq);
    res_t        r;
    int unsigned head, pos, n, p, steps;
    bit          head_bad, pos_bad, hit;
    r = '0;
    head = 32'(rq.list_head);
    pos = 32'(rq.position);
    head_bad = (head == 0) || (head >= Nodes);
    pos_bad = (pos == 0) || (pos >= Nodes);
    case (rq.operation)
      OP_MAKE_EMPTY: begin
        if (head >= Nodes) begin
          r.status = STAT_BAD_POS;
        end else begin
          // old list and its header go back first
          if (head != 0) begin
            release_chain(head);
            push_free(head);
          end
          n = pop_free();
          if (n == 0) begin
            r.status = STAT_SPACE;
          end else begin
            link_mem[n] = 0;
            r.found_position = PosW'(n);
          end
        end
      end
      OP_INSERT: begin
        if (pos_bad) begin
          r.status = STAT_BAD_POS;
        end else begin
          n = pop_free();
          if (n == 0) begin
            r.status = STAT_SPACE;
          end else begin
            elem_mem[n] = rq.value;
            link_mem[n] = link_mem[pos];
            link_mem[pos] = n;
            r.found_position = PosW'(n);
            r.previous_position = PosW'(pos);
          end
        end
      end
      OP_DELETE, OP_FIND: begin
        if (head_bad) begin
          r.status = STAT_BAD_POS;
        end else begin
          // walk for the first match, giving up after one pass over the store
          hit = 1'b0;
          p = head;
          n = link_mem[p];
          steps = 0;
          while (steps < Nodes && n != 0 && !hit) begin
            if (elem_mem[n] == rq.value) begin
              hit = 1'b1;
            end else begin
              p = n;
              n = link_mem[p];
              steps++;
            end
          end
          if (!hit) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            r.found_position = PosW'(n);
            r.previous_position = PosW'(p);
            if (rq.operation == OP_DELETE) begin
              link_mem[p] = link_mem[n];
              push_free(n);
            end
          end
        end
      end
      OP_DELETE_LIST: begin
        if (head_bad) r.status = STAT_BAD_POS;
        else release_chain(head);
      end
      OP_READ: begin
        if (pos_bad) begin
          r.status = STAT_BAD_POS;
        end else begin
          r.element = elem_mem[pos];
          r.next_position = PosW'(link_mem[pos]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void compare_field(string name, logic [ValW-1:0] want,
                                        logic [ValW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Result beats are checked before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Nodes; i++) begin
        link_mem[i] = (i == Nodes - 1) ? 0 : i + 1;
        elem_mem[i] = '0;
      end
      results_due.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          want = results_due.pop_front();
          compare_field("status", ValW'(want.status), ValW'(res_i.status));
          compare_field("found_position", ValW'(want.found_position),
                        ValW'(res_i.found_position));
          compare_field("previous_position", ValW'(want.previous_position),
                        ValW'(res_i.previous_position));
          compare_field("element", want.element, res_i.element);
          compare_field("next_position", ValW'(want.next_position),
                        ValW'(res_i.next_position));
        end
      end
      if (req_i.valid && req_i.ready) begin
        results_due.push_back(predict_result(in_item_t'{operation: req_i.operation,
                                                        value: req_i.value,
                                                        list_head: req_i.list_head,
                                                        position: req_i.position}));
      end
    end
    pending = results_due.size();
  end

endmodule

### tb/sv/tb_cursor_linked_list_engine.sv
// Testbench top of the cursor linked list engine: clock, reset, request traffic and verdict.
module tb_cursor_linked_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import clle_pkg::*;

  typedef enum {PH_MIXED, PH_FILL, PH_DRAIN, PH_NOISE} phase_e;

  // Operation codes the block has no name for
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;
  localparam int RandomItems = 1830;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   open_beats;
  bit   calm = 1'b0;

  clle_in_if  req_ch ();
  clle_out_if res_ch ();

  cursor_linked_list_engine DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_ch),
    .out_o (res_ch)
  );

  clle_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_ch),
    .res_i       (res_ch),
    .fail_count_o(mismatches),
    .open_count_o(open_beats)
  );

  // Rough map of the lists, used only to steer requests: header of each known node
  logic [PosW-1:0] owner_of [NodeCountDefault] = '{default: '0};
  in_item_t        sent_q [$];
  logic [PosW-1:0] tag_q [$];
  logic [PosW-1:0] last_found = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Any position, in range or not
  function automatic logic [PosW-1:0] rand_pos();
    return PosW'($urandom);
  endfunction

  function automatic void forget_list(logic [PosW-1:0] head, bit with_header);
    if (head != 0) begin
      for (int i = 1; i < NodeCountDefault; i++)
        if (owner_of[i] == head && (with_header || i != head)) owner_of[i] = '0;
    end
  endfunction

  // Random known node (or header); random position when nothing is known
  function automatic logic [PosW-1:0] pick_known(bit headers_only);
    logic [PosW-1:0] pool [$];
    for (int i = 1; i < NodeCountDefault; i++)
      if (owner_of[i] != 0 && (!headers_only || owner_of[i] == i)) pool.push_back(PosW'(i));
    if (pool.size() == 0) return PosW'($urandom_range(1, NodeCountDefault - 1));
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  // Small values collide often, so finds and deletes hit
  function automatic logic [ValW-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return ValW'($urandom_range(0, 7));
    if (roll < 60) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return '1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send(in_item_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= rq.operation;
    req_ch.value     <= rq.value;
    req_ch.list_head <= rq.list_head;
    req_ch.position  <= rq.position;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_q.push_back(rq);
    tag_q.push_back(rq.operation == OP_INSERT ? owner_of[rq.position] : '0);
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sent_q.size() != 0) @(posedge clk);
  endtask

  task automatic directed_item(logic [OpW-1:0] op, logic [ValW-1:0] value,
                               logic [PosW-1:0] head, logic [PosW-1:0] pos);
    send(in_item_t'{operation: op, value: value, list_head: head, position: pos});
    drain();
  endtask

  // Follow result beats to keep the list map current
  always @(posedge clk) begin
    in_item_t        rq;
    logic [PosW-1:0] tag;
    if (rst_n && res_ch.valid && res_ch.ready && sent_q.size() != 0) begin
      rq = sent_q.pop_front();
      tag = tag_q.pop_front();
      last_found = res_ch.found_position;
      case (rq.operation)
        OP_MAKE_EMPTY: begin
          if (res_ch.status != STAT_BAD_POS) forget_list(rq.list_head, 1'b1);
          if (res_ch.status == STAT_OK) owner_of[res_ch.found_position] = res_ch.found_position;
        end
        OP_INSERT: if (res_ch.status == STAT_OK && tag != 0) owner_of[res_ch.found_position] = tag;
        OP_DELETE: if (res_ch.status == STAT_OK) owner_of[res_ch.found_position] = '0;
        OP_DELETE_LIST: if (res_ch.status == STAT_OK) forget_list(rq.list_head, 1'b0);
        default: ;
      endcase
    end
  end

  // Result side back-pressure
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #200_000_000;
    $display("cursor_linked_list_engine regression: fail");
    $finish;
  end

  // Stimulus
  initial begin
    in_item_t        rq;
    logic [PosW-1:0] hdr, lost;
    phase_e          kind;
    int              span, total, roll;
    rst_n            <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= '0;
    req_ch.value     <= '0;
    req_ch.list_head <= '0;
    req_ch.position  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bad positions, extremes, every operation, runaway walk, spare codes
    directed_item(OP_READ, $urandom, rand_pos(), '0);
    directed_item(OP_READ, $urandom, rand_pos(), '1);
    directed_item(OP_MAKE_EMPTY, $urandom, '0, rand_pos());
    hdr = last_found;
    directed_item(OP_INSERT, 32'h7FFF_FFFF, rand_pos(), hdr);
    directed_item(OP_INSERT, 32'h8000_0000, rand_pos(), hdr);
    directed_item(OP_INSERT, '0, rand_pos(), hdr);
    directed_item(OP_INSERT, '1, rand_pos(), '0);
    directed_item(OP_FIND, 32'h8000_0000, hdr, rand_pos());
    directed_item(OP_FIND, 32'h1234_5678, hdr, rand_pos());
    directed_item(OP_FIND, '0, '0, rand_pos());
    directed_item(OP_DELETE, 32'h7FFF_FFFF, hdr, rand_pos());
    lost = last_found;
    directed_item(OP_DELETE, 32'h7FFF_FFFF, hdr, rand_pos());
    directed_item(OP_DELETE, '0, '0, rand_pos());
    directed_item(OP_READ, $urandom, rand_pos(), hdr);
    // the freed node now heads the free list: inserting after it links it to itself
    directed_item(OP_INSERT, 32'h0BAD_F00D, rand_pos(), lost);
    directed_item(OP_FIND, 32'h1234_5678, lost, rand_pos());
    directed_item(OP_DELETE_LIST, $urandom, lost, rand_pos());
    directed_item(OP_DELETE_LIST, $urandom, hdr, rand_pos());
    directed_item(OP_DELETE_LIST, $urandom, '0, rand_pos());
    directed_item(OP_INSERT, 32'd5, rand_pos(), hdr);
    directed_item(OP_MAKE_EMPTY, $urandom, hdr, rand_pos());
    directed_item(OpSpareLo, $urandom, rand_pos(), rand_pos());
    directed_item(OpSpareHi, $urandom, rand_pos(), rand_pos());
    directed_item(OP_READ, $urandom, rand_pos(), 8'h01);

    // Random phases: a fill phase first, then a drain, then a random mix of phases
    total = 0;
    kind = PH_FILL;
    while (total < RandomItems) begin
      span = (kind == PH_FILL) ? 400 : (kind == PH_DRAIN) ? 250 :
             (kind == PH_NOISE) ? 40 : $urandom_range(120, 300);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < span && total < RandomItems; k++) begin
        if ($urandom_range(0, 3) != 0) drain();
        rq.value = $urandom;
        rq.list_head = rand_pos();
        rq.position = rand_pos();
        roll = $urandom_range(0, 99);
        case (kind)
          PH_NOISE: rq.operation = OpW'($urandom_range(0, 7));
          PH_FILL:  rq.operation = roll < 80 ? OP_INSERT : roll < 88 ? OP_MAKE_EMPTY :
                                   roll < 94 ? OP_FIND : roll < 98 ? OP_READ : OP_DELETE;
          PH_DRAIN: rq.operation = roll < 35 ? OP_DELETE : roll < 50 ? OP_DELETE_LIST :
                                   roll < 70 ? OP_FIND : roll < 85 ? OP_MAKE_EMPTY :
                                   roll < 95 ? OP_READ : OP_INSERT;
          default:  rq.operation = roll < 10 ? OP_MAKE_EMPTY : roll < 45 ? OP_INSERT :
                                   roll < 60 ? OP_DELETE : roll < 80 ? OP_FIND :
                                   roll < 85 ? OP_DELETE_LIST : roll < 98 ? OP_READ :
                                   roll < 99 ? OpSpareLo : OpSpareHi;
        endcase
        roll = $urandom_range(0, 99);
        if (kind != PH_NOISE) begin
          case (rq.operation)
            OP_MAKE_EMPTY: rq.list_head = roll < 45 ? '0 : roll < 92 ? pick_known(1'b1) :
                                          rq.list_head;
            OP_INSERT: begin
              rq.value = pick_value();
              rq.position = roll < 88 ? pick_known(1'b0) : roll < 97 ? rq.position : '0;
            end
            OP_DELETE, OP_FIND: begin
              rq.value = pick_value();
              rq.list_head = roll < 90 ? pick_known(1'b1) : roll < 96 ? rq.list_head : '0;
            end
            OP_DELETE_LIST: rq.list_head = roll < 94 ? pick_known(1'b1) :
                                           roll < 97 ? rq.list_head : '0;
            OP_READ: rq.position = roll < 55 ? pick_known(1'b0) : rq.position;
            default: ;
          endcase
        end
        send(rq);
        total++;
      end
      roll = $urandom_range(0, 99);
      if (kind == PH_FILL && total < 500) kind = PH_DRAIN;
      else kind = roll < 50 ? PH_MIXED : roll < 72 ? PH_FILL : roll < 92 ? PH_DRAIN : PH_NOISE;
    end

    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && open_beats == 0) begin
      $display("cursor_linked_list_engine regression: pass");
    end else begin
      $display("cursor_linked_list_engine regression: fail");
    end
    $finish;
  end

endmodule
